>>> rtl/core/fp16_dot_product_fp32_accumulate_unit_defines.svh
// assertion macros for the fp16 dot product unit
// the enclosing module provides clk_i and rst_ni
`ifndef FP16_DOT_PRODUCT_FP32_ACCUMULATE_UNIT_DEFINES_SVH
`define FP16_DOT_PRODUCT_FP32_ACCUMULATE_UNIT_DEFINES_SVH

// same-cycle implication
`define FPDP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpdp same-cycle check failed");

// next-cycle implication
`define FPDP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpdp next-cycle check failed");

`endif

>>> rtl/core/fpdp_pkg.sv
package fpdp_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  // one queued word: both exact products plus the accumulator operand
  typedef struct packed {
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] acc;
    logic        last;
  } fpdp_entry_t;

  // adder state between alignment and rounding
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sign;
    logic [8:0]  exp;
    logic [27:0] mag;
  } fpdp_align_t;

  typedef enum logic [2:0] {
    FPDP_IDLE,
    FPDP_PAIR_AL,
    FPDP_PAIR_RN,
    FPDP_SUM_AL,
    FPDP_SUM_RN,
    FPDP_ACC_AL,
    FPDP_ACC_RN
  } fpdp_state_e;

  typedef struct packed {
    logic pop;
    logic ld_s1;
    logic ld_pair;
    logic ld_sum;
    logic ld_out;
  } fpdp_ctl_t;

  typedef struct packed {
    logic        busy;
    fpdp_state_e state;
  } fpdp_status_t;

  // exact binary16 to binary32 widening
  function automatic logic [31:0] f16_widen(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [9:0] mn;
    logic [3:0] lz;
    logic       found;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz = 4'(9 - i);
        found = 1'b1;
      end
    end
    mn = 10'(m << (lz + 4'd1));
    if (e == 5'h1F) begin
      r = {h[15], 8'hFF, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'd112 - {4'd0, lz}, mn, 13'd0};
    end else begin
      r = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  // product of two widened halves, exact in binary32
  function automatic logic [31:0] f32_mul_exact(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic        na, nb, ia, ib, za, zb;
    logic [21:0] p;
    logic [9:0]  e;
    logic [9:0]  e1;
    logic [31:0] r;
    s  = a[31] ^ b[31];
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    za = (a[30:23] == 8'd0);
    zb = (b[30:23] == 8'd0);
    p  = {1'b1, a[22:13]} * {1'b1, b[22:13]};
    e  = {2'd0, a[30:23]} + {2'd0, b[30:23]} - 10'd127;
    e1 = e + 10'd1;
    if (na || nb || (ia && zb) || (za && ib)) r = QNAN_BITS;
    else if (ia || ib) r = {s, 8'hFF, 23'd0};
    else if (za || zb) r = {s, 31'd0};
    else if (p[21]) r = {s, e1[7:0], p[20:0], 2'd0};
    else r = {s, e[7:0], p[19:0], 3'd0};
    return r;
  endfunction

  // first adder half: order, align with sticky, add or subtract
  function automatic fpdp_align_t f32_add_align(input logic [31:0] x, input logic [31:0] y);
    logic        xn, yn, xi, yi;
    logic [31:0] bg, sm;
    logic [7:0]  eb, es, d;
    logic [4:0]  d5;
    logic [26:0] xb, ys, sh;
    logic        lost;
    fpdp_align_t r;
    xn = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    yn = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    xi = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    yi = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    if (x[30:0] >= y[30:0]) begin
      bg = x;
      sm = y;
    end else begin
      bg = y;
      sm = x;
    end
    eb = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d  = eb - es;
    d5 = (d > 8'd27) ? 5'd27 : d[4:0];
    xb = {bg[30:23] != 8'd0, bg[22:0], 3'd0};
    ys = {sm[30:23] != 8'd0, sm[22:0], 3'd0};
    sh = ys >> d5;
    lost = |(ys & ~(27'h7FF_FFFF << d5));
    sh[0] = sh[0] | lost;
    r.exp = {1'b0, eb};
    r.nan = xn || yn || (xi && yi && (x[31] != y[31]));
    r.inf = xi || yi;
    if (bg[31] == sm[31]) r.mag = {1'b0, xb} + {1'b0, sh};
    else r.mag = {1'b0, xb} - {1'b0, sh};
    if (xi || yi) r.sign = xi ? x[31] : y[31];
    else if ((bg[31] != sm[31]) && (r.mag == 28'd0)) r.sign = 1'b0;
    else r.sign = bg[31];
    return r;
  endfunction

  // second adder half: normalize, round to nearest even, pack
  function automatic logic [31:0] f32_add_round(input fpdp_align_t a);
    logic [26:0] n;
    logic [8:0]  e;
    logic [8:0]  lim;
    logic [4:0]  lz;
    logic [8:0]  sh;
    logic        found;
    logic [7:0]  ef;
    logic        rnd;
    logic [30:0] body;
    logic [31:0] r;
    lz = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && a.mag[i]) begin
        lz = 5'(26 - i);
        found = 1'b1;
      end
    end
    lim = a.exp - 9'd1;
    sh  = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
    if (a.mag[27]) begin
      n = {a.mag[27:2], a.mag[1] | a.mag[0]};
      e = a.exp + 9'd1;
    end else begin
      n = a.mag[26:0] << sh;
      e = a.exp - sh;
    end
    ef   = n[26] ? e[7:0] : 8'd0;
    rnd  = n[2] & (n[1] | n[0] | n[3]);
    body = {ef, n[25:3]} + {30'd0, rnd};
    if (a.nan) r = QNAN_BITS;
    else if (a.inf || (e >= 9'd255)) r = {a.sign, 8'hFF, 23'd0};
    else r = {a.sign, body};
    return r;
  endfunction

endpackage

>>> rtl/core/fpdp_front.sv
module fpdp_front
  import fpdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] a_pair_i,
  input  logic [31:0] b_pair_i,
  input  logic [31:0] acc_in_i,
  input  logic        last_i,
  output logic        push_o,
  output fpdp_entry_t entry_o,
  input  logic        q_full_i
);

  logic        valid_q, valid_d;
  fpdp_entry_t entry_q;
  logic        take;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign entry_o    = entry_q;

  always_comb begin
    valid_d = valid_q;
    if (take) valid_d = 1'b1;
    else if (push_o) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  // products are exact, so they are formed right at the input
  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q.p0   <= f32_mul_exact(f16_widen(a_pair_i[15:0]), f16_widen(b_pair_i[15:0]));
      entry_q.p1   <= f32_mul_exact(f16_widen(a_pair_i[31:16]), f16_widen(b_pair_i[31:16]));
      entry_q.acc  <= acc_in_i;
      entry_q.last <= last_i;
    end
  end

endmodule

>>> rtl/core/fpdp_queue.sv
module fpdp_queue
  import fpdp_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  fpdp_entry_t                entry_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output fpdp_entry_t                head_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fpdp_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign level_o = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i) rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

>>> rtl/core/fpdp_back.sv
module fpdp_back
  import fpdp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  fpdp_entry_t  q_head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  result_o,
  output fpdp_status_t status_o
);

  fpdp_state_e state_q, state_d;
  fpdp_ctl_t   ctl;
  fpdp_entry_t cur_q;
  fpdp_align_t s1_q;
  logic [31:0] pair_q, sum_q, result_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic [31:0] op_a, op_b, rnd;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rnd      = f32_add_round(s1_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FPDP_IDLE:    if (q_valid_i) state_d = FPDP_PAIR_AL;
      FPDP_PAIR_AL: state_d = FPDP_PAIR_RN;
      FPDP_PAIR_RN: state_d = FPDP_SUM_AL;
      FPDP_SUM_AL:  state_d = FPDP_SUM_RN;
      FPDP_SUM_RN: begin
        if (cur_q.last) state_d = FPDP_ACC_AL;
        else state_d = q_valid_i ? FPDP_PAIR_AL : FPDP_IDLE;
      end
      FPDP_ACC_AL:  state_d = FPDP_ACC_RN;
      FPDP_ACC_RN: begin
        if (out_free) state_d = q_valid_i ? FPDP_PAIR_AL : FPDP_IDLE;
      end
      default:      state_d = FPDP_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    op_a = sum_q;
    op_b = pair_q;
    unique case (state_q)
      FPDP_IDLE:    ctl.pop = q_valid_i;
      FPDP_PAIR_AL: begin
        ctl.ld_s1 = 1'b1;
        op_a = cur_q.p0;
        op_b = cur_q.p1;
      end
      FPDP_PAIR_RN: ctl.ld_pair = 1'b1;
      FPDP_SUM_AL:  ctl.ld_s1 = 1'b1;
      FPDP_SUM_RN: begin
        ctl.ld_sum = 1'b1;
        ctl.pop    = !cur_q.last && q_valid_i;
      end
      FPDP_ACC_AL: begin
        ctl.ld_s1 = 1'b1;
        op_b = cur_q.acc;
      end
      FPDP_ACC_RN: begin
        ctl.ld_out = out_free;
        ctl.pop    = out_free && q_valid_i;
      end
      default:      ctl = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.ld_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FPDP_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ctl.ld_out) sum_q <= '0;
      else if (ctl.ld_sum) sum_q <= rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.pop) cur_q <= q_head_i;
    if (ctl.ld_s1) s1_q <= f32_add_align(op_a, op_b);
    if (ctl.ld_pair) pair_q <= rnd;
    if (ctl.ld_out) result_q <= rnd;
  end

  assign pop_o           = ctl.pop;
  assign out_valid_o     = out_valid_q;
  assign result_o        = result_q;
  assign status_o.busy   = (state_q != FPDP_IDLE);
  assign status_o.state  = state_q;

endmodule

>>> rtl/core/fp16_dot_product_fp32_accumulate_unit.sv
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------
// input    | in_valid_i / in_stall_o   | a_pair_i, b_pair_i, acc_in_i, last_i
// output   | out_valid_o / out_stall_i | result_o
//
// in the back end a word makes two passes of the shared two-stage fp32 adder
// (p0 + p1, then the running sum plus that pair); a word marked last makes a
// third, adding acc_in_i; a new word is taken only once the last is through
// reset clears the running sum to +0, the queue and both valid flags
// the front keeps taking words while the queue has room, even with a result held
`include "fp16_dot_product_fp32_accumulate_unit_defines.svh"

module fp16_dot_product_fp32_accumulate_unit
  import fpdp_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] a_pair_i,
  input  logic [31:0] b_pair_i,
  input  logic [31:0] acc_in_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_o
);

  localparam int LevelW = $clog2(QueueDepth + 1);

  // front to queue
  logic        push;
  fpdp_entry_t push_entry;
  logic        q_full;

  // queue to back
  logic              q_valid;
  fpdp_entry_t       q_head;
  logic              pop;
  logic [LevelW-1:0] q_level;

  fpdp_status_t back_st;

  // decode halves and form the exact products
  fpdp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .a_pair_i   (a_pair_i),
    .b_pair_i   (b_pair_i),
    .acc_in_i   (acc_in_i),
    .last_i     (last_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .q_full_i   (q_full)
  );

  // decouples the product stage from the adder loop
  fpdp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .level_o (q_level)
  );

  // sequenced accumulation and output register
  fpdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .status_o    (back_st)
  );

  // a result only appears after the final rounding pass
  `FPDP_ASSERT_IMP(a_out_after_round, $rose(out_valid_o), $past(back_st.state == FPDP_ACC_RN))
  // queue never holds more than its depth
  `FPDP_ASSERT_IMP(a_queue_level, 1'b1, q_level <= LevelW'(QueueDepth))
  // final pass waits while the held result is not taken
  `FPDP_ASSERT_NXT(a_hold_final, (back_st.state == FPDP_ACC_RN) && out_valid_o && out_stall_i,
                   back_st.state == FPDP_ACC_RN)

endmodule
